>>> hw/rtl/mpot_pkg.sv
// ----------------------------------------------------------------------------
// mpot_pkg: shared constants and types of the MPO trace chain
// Widths, fixed-point formats and the structs passed between the modules.
// ----------------------------------------------------------------------------
package mpot_pkg;

  // Bond and physical index limits.
  localparam int BOND_MAX = 64;
  localparam int PHYS_MAX = 8;
  localparam int BOND_W   = $clog2(BOND_MAX);

  // Fixed field widths of the item and result.
  localparam int IDX_W      = 6;
  localparam int PHYS_W     = 3;
  localparam int PHYS_DIM_W = 4;
  localparam int VAL_W      = 32;   // Q4.28
  localparam int ACC_W      = 48;   // Q16.32

  localparam logic [PHYS_DIM_W-1:0] PHYS_DIM_RST = PHYS_DIM_W'(2);

  // Product arithmetic: the carry entry is split into two halves.
  localparam int VAL_FRAC = 28;
  localparam int HALF_W   = ACC_W / 2;
  localparam int PP_W     = HALF_W + VAL_W;
  localparam int RND_SH   = VAL_FRAC - HALF_W;
  localparam int PROD_W   = PP_W + 1 - RND_SH;
  localparam int SUM_W    = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] ONE_Q32 = {{(ACC_W-33){1'b0}}, 1'b1, 32'd0};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Write request into one vector bank.
  typedef struct packed {
    logic                    en;
    logic [BOND_W-1:0]       addr;
    logic signed [ACC_W-1:0] data;
  } bank_wr_t;

  // One result item.
  typedef struct packed {
    logic signed [ACC_W-1:0] trace_value;
    logic                    saturated;
  } result_t;

endpackage

>>> hw/rtl/mpot_chan_if.sv
// ----------------------------------------------------------------------------
// mpot_chan_if: item and result channels of the MPO trace chain
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// Input channel: one site tensor element per transfer.
interface mpot_item_if;
  logic                              valid;
  logic                              ready;
  logic [mpot_pkg::IDX_W-1:0]        row_index;
  logic [mpot_pkg::IDX_W-1:0]        col_index;
  logic [mpot_pkg::PHYS_W-1:0]       phys_out;
  logic [mpot_pkg::PHYS_W-1:0]       phys_in;
  logic signed [mpot_pkg::VAL_W-1:0] elem_value;
  logic                              site_end;
  logic                              chain_end;

  modport source (
    output valid, row_index, col_index, phys_out, phys_in, elem_value, site_end,
           chain_end,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_index, phys_out, phys_in, elem_value, site_end,
           chain_end,
    output ready
  );
endinterface

// Output channel: one trace per transfer.
interface mpot_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [mpot_pkg::ACC_W-1:0] trace_value;
  logic                              saturated;

  modport source (output valid, trace_value, saturated, input ready);
  modport sink (input valid, trace_value, saturated, output ready);
endinterface

>>> hw/rtl/mpo_trace_chain.sv
// A trace reaches the result channel once its chain_end element has passed
//   the carry read, two multiplier stages, accumulate and the result buffer.
// Throughput: one element per cycle inside a site while the result buffer is
//   not full; after a site_end or chain_end element it pauses until write-back.
// Reset: asynchronous; the vector returns to the unit vector, phys_dim to 2,
//   with per-entry valid bits instead of a clearing pass.
// ----------------------------------------------------------------------------
// mpo_trace_chain: trace of a matrix product operator
// Streams site tensor elements through a chain of vector-matrix products
// held in two ping-pong banks and emits entry 0 at the end of the chain.
// ----------------------------------------------------------------------------
module mpo_trace_chain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  phys_dim_we_i,
  input  logic [mpot_pkg::PHYS_DIM_W-1:0]       phys_dim_wdata_i,
  mpot_item_if.sink                             item_i,
  mpot_result_if.source                         result_o
);

  // Configuration and chain state.
  logic [mpot_pkg::PHYS_DIM_W-1:0] phys_dim_q;
  logic                            carry_sel_q;   // bank holding the carry vector
  logic                            carry_unit_q;  // carry is still the unit vector
  logic                            overflow_q;
  logic signed [mpot_pkg::ACC_W-1:0] next0_q;     // entry 0 of the next vector

  // Pipeline registers.
  logic                              s1_v_q, s2_v_q, s3_v_q;
  logic                              s1_end_q, s2_end_q, s3_end_q;
  logic                              s1_chain_q, s2_chain_q, s3_chain_q;
  logic                              s1_cnt_q, s2_cnt_q, s3_cnt_q;
  logic [mpot_pkg::BOND_W-1:0]       s1_col_q, s2_col_q, s3_col_q;
  logic                              s1_row0_q;
  logic                              s1_unit_q;
  logic signed [mpot_pkg::VAL_W-1:0] s1_val_q;

  // Forwarding of the most recent write to the next vector.
  logic                              lw_v_q;
  logic [mpot_pkg::BOND_W-1:0]       lw_addr_q;
  logic signed [mpot_pkg::ACC_W-1:0] lw_data_q;

  logic                              in_xfer;
  logic                              end_in_flight;
  logic                              fifo_full;
  logic                              counted_d;
  logic [mpot_pkg::BOND_W-1:0]       row_addr;
  logic [mpot_pkg::BOND_W-1:0]       col_addr;

  mpot_pkg::bank_wr_t                bank0_wr, bank1_wr;
  logic                              bank0_clr, bank1_clr;
  logic [mpot_pkg::BOND_W-1:0]       bank0_rd_addr, bank1_rd_addr;
  logic signed [mpot_pkg::ACC_W-1:0] bank0_rd, bank1_rd;

  logic signed [mpot_pkg::ACC_W-1:0] carry_rd, carry_val;
  logic signed [mpot_pkg::PROD_W-1:0] prod;
  logic signed [mpot_pkg::ACC_W-1:0] next_rd, next_cur;
  logic signed [mpot_pkg::SUM_W-1:0] sum;
  logic [mpot_pkg::SUM_W-mpot_pkg::ACC_W:0] sum_top;
  logic                              acc_ovf_raw;
  logic signed [mpot_pkg::ACC_W-1:0] sat_sum;
  logic                              wr_en;
  logic                              acc_ovf;
  logic                              s3_end, s3_chain;
  mpot_pkg::result_t                 res_d;

  // Input handshake: hold off while an end mark is on its way to write-back or the result buffer is full.
  assign end_in_flight = (s1_v_q & s1_end_q) | (s2_v_q & s2_end_q) | (s3_v_q & s3_end_q);
  assign item_i.ready  = ~end_in_flight & ~fifo_full;
  assign in_xfer       = item_i.valid & item_i.ready;

  // Element selection: diagonal physical index in use, bond indices in range.
  assign row_addr = mpot_pkg::BOND_W'(item_i.row_index);
  assign col_addr = mpot_pkg::BOND_W'(item_i.col_index);
  assign counted_d = (item_i.phys_out == item_i.phys_in)
                   && (mpot_pkg::PHYS_DIM_W'(item_i.phys_out) < phys_dim_q)
                   && (32'(item_i.phys_out) < mpot_pkg::PHYS_MAX)
                   && (32'(item_i.row_index) < mpot_pkg::BOND_MAX)
                   && (32'(item_i.col_index) < mpot_pkg::BOND_MAX);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_dim_q <= mpot_pkg::PHYS_DIM_RST;
    end else if (phys_dim_we_i) begin
      phys_dim_q <= phys_dim_wdata_i;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_xfer;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_end_q   <= item_i.site_end | item_i.chain_end;
    s1_chain_q <= item_i.chain_end;
    s1_cnt_q   <= counted_d;
    s1_col_q   <= col_addr;
    s1_row0_q  <= (item_i.row_index == '0);
    s1_unit_q  <= carry_unit_q;
    s1_val_q   <= item_i.elem_value;
    s2_end_q   <= s1_end_q;
    s2_chain_q <= s1_chain_q;
    s2_cnt_q   <= s1_cnt_q;
    s2_col_q   <= s1_col_q;
    s3_end_q   <= s2_end_q;
    s3_chain_q <= s2_chain_q;
    s3_cnt_q   <= s2_cnt_q;
    s3_col_q   <= s2_col_q;
  end

  // Bank ports: the carry bank is read at the incoming row, the next bank at
  // the column of the item that enters the accumulate stage.
  assign bank0_rd_addr = carry_sel_q ? s2_col_q : row_addr;
  assign bank1_rd_addr = carry_sel_q ? row_addr : s2_col_q;

  mpot_bank u_bank0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (bank0_clr),
    .wr_i      (bank0_wr),
    .rd_addr_i (bank0_rd_addr),
    .rd_data_o (bank0_rd)
  );

  mpot_bank u_bank1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (bank1_clr),
    .wr_i      (bank1_wr),
    .rd_addr_i (bank1_rd_addr),
    .rd_data_o (bank1_rd)
  );

  // Carry entry for the multiplier, with the unit vector after reset or a chain end.
  assign carry_rd  = carry_sel_q ? bank1_rd : bank0_rd;
  assign carry_val = s1_unit_q ? (s1_row0_q ? mpot_pkg::ONE_Q32 : '0) : carry_rd;

  mpot_qmul u_qmul (
    .clk_i  (clk_i),
    .a_i    (carry_val),
    .b_i    (s1_val_q),
    .prod_o (prod)
  );

  // Accumulate stage: forward the previous write, add, saturate.
  always_comb begin
    next_rd     = carry_sel_q ? bank0_rd : bank1_rd;
    next_cur    = (lw_v_q && (lw_addr_q == s3_col_q)) ? lw_data_q : next_rd;
    sum         = mpot_pkg::SUM_W'(next_cur) + mpot_pkg::SUM_W'(prod);
    sum_top     = sum[mpot_pkg::SUM_W-1:mpot_pkg::ACC_W-1];
    acc_ovf_raw = ~((&sum_top) | ~(|sum_top));
    if (acc_ovf_raw) begin
      sat_sum = sum[mpot_pkg::SUM_W-1] ? mpot_pkg::ACC_MIN : mpot_pkg::ACC_MAX;
    end else begin
      sat_sum = sum[mpot_pkg::ACC_W-1:0];
    end
  end

  assign wr_en    = s3_v_q & s3_cnt_q;
  assign acc_ovf  = wr_en & acc_ovf_raw;
  assign s3_end   = s3_v_q & s3_end_q;
  assign s3_chain = s3_v_q & s3_chain_q;

  // Write-back into the next bank; a site end clears the old carry bank,
  // which becomes the next bank, and a chain end clears both.
  always_comb begin
    bank0_wr.en   = wr_en & carry_sel_q;
    bank0_wr.addr = s3_col_q;
    bank0_wr.data = sat_sum;
    bank1_wr.en   = wr_en & ~carry_sel_q;
    bank1_wr.addr = s3_col_q;
    bank1_wr.data = sat_sum;
    bank0_clr     = s3_chain | (s3_end & ~carry_sel_q);
    bank1_clr     = s3_chain | (s3_end & carry_sel_q);
  end

  // Chain state updates at write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_sel_q  <= 1'b0;
      carry_unit_q <= 1'b1;
      overflow_q   <= 1'b0;
      next0_q      <= '0;
      lw_v_q       <= 1'b0;
    end else begin
      lw_v_q <= wr_en & ~s3_end;
      if (s3_chain) begin
        carry_sel_q  <= 1'b0;
        carry_unit_q <= 1'b1;
        overflow_q   <= 1'b0;
      end else begin
        if (s3_end) begin
          carry_sel_q  <= ~carry_sel_q;
          carry_unit_q <= 1'b0;
        end
        if (acc_ovf) begin
          overflow_q <= 1'b1;
        end
      end
      if (s3_end) begin
        next0_q <= '0;
      end else if (wr_en && (s3_col_q == '0)) begin
        next0_q <= sat_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lw_addr_q <= s3_col_q;
    lw_data_q <= sat_sum;
  end

  // Result: entry 0 of the vector that this element completes.
  assign res_d.trace_value = (wr_en && (s3_col_q == '0)) ? sat_sum : next0_q;
  assign res_d.saturated   = overflow_q | acc_ovf;

  mpot_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_chain),
    .push_data_i (res_d),
    .full_o      (fifo_full),
    .result_o    (result_o)
  );

`ifndef SYNTH
  // Only one end-marked element may be in the pipeline at a time.
  a_one_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({s1_v_q & s1_end_q, s2_v_q & s2_end_q, s3_v_q & s3_end_q}) <= 1)
    else $error("more than one end-marked element in flight");

  // A finished trace always finds room in the result buffer.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_chain |-> !fifo_full)
    else $error("result pushed into a full buffer");

  // A chain end leaves the unit vector and a clear overflow flag behind.
  a_chain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_chain |=> (carry_unit_q && !overflow_q && !lw_v_q))
    else $error("chain state not restored after chain end");

  // A site end that is not a chain end swaps the bank roles.
  a_site_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_end && !s3_chain) |=> (carry_sel_q != $past(carry_sel_q)))
    else $error("bank roles not swapped at site end");
`endif

endmodule

>>> hw/rtl/mpot_bank.sv
// ----------------------------------------------------------------------------
// mpot_bank: one vector bank of the MPO trace chain
// A 1-write, 1-read memory with registered read data and per-entry valid
// bits; an entry that is not valid reads as zero, and clear empties all.
// ----------------------------------------------------------------------------
module mpot_bank (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  mpot_pkg::bank_wr_t                   wr_i,
  input  logic [mpot_pkg::BOND_W-1:0]          rd_addr_i,
  output logic signed [mpot_pkg::ACC_W-1:0]    rd_data_o
);

  logic signed [mpot_pkg::ACC_W-1:0] mem_q [mpot_pkg::BOND_MAX];
  logic signed [mpot_pkg::ACC_W-1:0] rd_q;
  logic [mpot_pkg::BOND_MAX-1:0]     valid_q;
  logic                              rd_valid_q;

  // Memory array: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Valid bits; a clear takes priority over a write in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

>>> hw/rtl/mpot_qmul.sv
// ----------------------------------------------------------------------------
// mpot_qmul: two-stage Q16.32 by Q4.28 multiplier
// Splits the 48-bit operand into halves, registers the two partial
// products, then combines and rounds to nearest (ties up) into Q21.32.
// ----------------------------------------------------------------------------
module mpot_qmul (
  input  logic                                  clk_i,
  input  logic signed [mpot_pkg::ACC_W-1:0]     a_i,
  input  logic signed [mpot_pkg::VAL_W-1:0]     b_i,
  output logic signed [mpot_pkg::PROD_W-1:0]    prod_o
);

  localparam logic signed [mpot_pkg::PP_W:0] RND =
    (mpot_pkg::PP_W + 1)'(1) << (mpot_pkg::VAL_FRAC - 1);

  logic signed [mpot_pkg::HALF_W-1:0]          hi;
  logic [mpot_pkg::HALF_W-1:0]                 lo;
  logic signed [mpot_pkg::PP_W-1:0]            p1_d, p1_q;
  logic signed [mpot_pkg::PP_W-1:0]            p0_d, p0_q;
  logic signed [mpot_pkg::PP_W:0]              rnd;
  logic signed [mpot_pkg::PP_W-mpot_pkg::HALF_W:0] low_part;
  logic signed [mpot_pkg::PP_W:0]              full;
  logic signed [mpot_pkg::PROD_W-1:0]          prod_q;

  // Stage A: signed upper half and unsigned lower half times the value.
  always_comb begin
    hi   = a_i[mpot_pkg::ACC_W-1:mpot_pkg::HALF_W];
    lo   = a_i[mpot_pkg::HALF_W-1:0];
    p1_d = mpot_pkg::PP_W'(hi) * mpot_pkg::PP_W'(b_i);
    p0_d = mpot_pkg::PP_W'($signed({1'b0, lo})) * mpot_pkg::PP_W'(b_i);
  end

  // Stage B: round the lower product, add the upper one, drop the extra fraction bits.
  always_comb begin
    rnd      = (mpot_pkg::PP_W + 1)'(p0_q) + RND;
    low_part = rnd[mpot_pkg::PP_W:mpot_pkg::HALF_W];
    full     = (mpot_pkg::PP_W + 1)'(p1_q) + (mpot_pkg::PP_W + 1)'(low_part);
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    p0_q   <= p0_d;
    prod_q <= full[mpot_pkg::PP_W:mpot_pkg::RND_SH];
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/mpot_out_fifo.sv
// ----------------------------------------------------------------------------
// mpot_out_fifo: two-entry result buffer of the MPO trace chain
// Decouples finished traces from the result channel so the input side
// keeps moving while a result waits to be taken, until both entries are full.
// ----------------------------------------------------------------------------
module mpot_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mpot_pkg::result_t push_data_i,
  output logic              full_o,
  mpot_result_if.source     result_o
);

  mpot_pkg::result_t data_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  assign pop = result_o.valid & result_o.ready;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign full_o               = (count_q == 2'd2);
  assign result_o.valid       = (count_q != 2'd0);
  assign result_o.trace_value = data_q[rd_ptr_q].trace_value;
  assign result_o.saturated   = data_q[rd_ptr_q].saturated;

endmodule
